// ===== rtl/infix_to_prefix_converter_unit_assert.svh =====
// Assertion macros for the infix to prefix converter.
`ifndef INFIX_TO_PREFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_PREFIX_CONVERTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define I2P_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define I2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define I2P_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define I2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/i2p_pkg.sv =====
// Package with constants, types and helper functions of the infix to prefix converter.
`timescale 1ns / 1ps
package i2p_pkg;

    localparam int MAX_LEN = 32;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Precedence codes, offset by one so that the lowest level is zero.
    localparam logic [2:0] PREC_NONE = 3'd0;
    localparam logic [2:0] PREC_ADD  = 3'd2;
    localparam logic [2:0] PREC_MUL  = 3'd3;
    localparam logic [2:0] PREC_POW  = 3'd4;

    typedef struct packed {
        logic load;
        logic start;
        logic rd_in;
        logic emit_cur;
        logic push_cur;
        logic rd_top;
        logic pop_emit;
        logic drop_top;
        logic rd_out;
        logic out_empty;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic idx_zero;
        logic sp_zero;
        logic oc_zero;
        logic cur_operand;
        logic cur_open;
        logic cur_close;
        logic pop_ok;
        logic top_open;
    } t_status;

    function automatic logic [2:0] prec_code(input logic [7:0] c);
        logic [2:0] p;
        p = PREC_NONE;
        if (c == CH_CARET) begin
            p = PREC_POW;
        end else if ((c == CH_STAR) || (c == CH_SLASH)) begin
            p = PREC_MUL;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            p = PREC_ADD;
        end
        return p;
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
               ((c >= CH_ZERO) && (c <= CH_NINE));
    endfunction

    function automatic logic [7:0] swap_paren(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_OPEN) begin
            r = CH_CLOSE;
        end else if (c == CH_CLOSE) begin
            r = CH_OPEN;
        end
        return r;
    endfunction

endpackage

// ===== rtl/i2p_datapath.sv =====
// Datapath of the infix to prefix converter: buffers, operator stack and counters.
`timescale 1ns / 1ps
module i2p_datapath
    import i2p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_char,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [7:0]  o_char,
    output logic        o_has_char,
    output logic        o_last,
    output logic        o_overflow
);

    logic [7:0] in_mem  [MAX_LEN];
    logic [7:0] stk_mem [MAX_LEN];
    logic [7:0] out_mem [MAX_LEN];

    logic [CNT_W-1:0] r_in_cnt, n_in_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_sp, n_sp;
    logic [CNT_W-1:0] r_oc, n_oc;
    logic             r_ovf, n_ovf;
    logic             r_has;
    logic [7:0]       r_in_q;
    logic [7:0]       r_stk_q;
    logic [7:0]       r_out_q;

    logic [CNT_W-1:0] idx_m1, sp_m1, oc_m1;
    logic [7:0]       cur_char;
    logic [2:0]       cur_prec, top_prec;
    logic             out_wr;
    logic [7:0]       out_wdata;

    assign idx_m1   = r_idx - CNT_W'(1);
    assign sp_m1    = r_sp - CNT_W'(1);
    assign oc_m1    = r_oc - CNT_W'(1);
    assign cur_char = swap_paren(r_in_q);
    assign cur_prec = prec_code(cur_char);
    assign top_prec = prec_code(r_stk_q);

    assign out_wr    = (i_cmd.emit_cur || i_cmd.pop_emit) && (r_oc < CNT_W'(MAX_LEN));
    assign out_wdata = i_cmd.pop_emit ? r_stk_q : cur_char;

    always_comb begin
        n_in_cnt = r_in_cnt;
        n_ovf    = r_ovf;
        n_idx    = r_idx;
        n_sp     = r_sp;
        n_oc     = r_oc;
        if (i_cmd.load) begin
            if (r_in_cnt < CNT_W'(MAX_LEN)) begin
                n_in_cnt = r_in_cnt + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.start) begin
            n_idx = r_in_cnt;
            n_sp  = '0;
            n_oc  = '0;
        end
        if (i_cmd.rd_in) begin
            n_idx = idx_m1;
        end
        if (out_wr) begin
            n_oc = r_oc + CNT_W'(1);
        end
        if (i_cmd.push_cur && (r_sp < CNT_W'(MAX_LEN))) begin
            n_sp = r_sp + CNT_W'(1);
        end
        if (i_cmd.pop_emit || i_cmd.drop_top) begin
            n_sp = sp_m1;
        end
        if (i_cmd.rd_out) begin
            n_oc = oc_m1;
        end
        if (i_cmd.clear) begin
            n_in_cnt = '0;
            n_ovf    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_sp     <= '0;
            r_oc     <= '0;
        end else begin
            r_in_cnt <= n_in_cnt;
            r_ovf    <= n_ovf;
            r_idx    <= n_idx;
            r_sp     <= n_sp;
            r_oc     <= n_oc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_in_cnt < CNT_W'(MAX_LEN))) begin
            in_mem[r_in_cnt[ADDR_W-1:0]] <= i_char;
        end
        if (i_cmd.rd_in) begin
            r_in_q <= in_mem[idx_m1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_cur && (r_sp < CNT_W'(MAX_LEN))) begin
            stk_mem[r_sp[ADDR_W-1:0]] <= cur_char;
        end
        if (i_cmd.rd_top) begin
            r_stk_q <= stk_mem[sp_m1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            out_mem[r_oc[ADDR_W-1:0]] <= out_wdata;
        end
        if (i_cmd.rd_out) begin
            r_out_q <= out_mem[oc_m1[ADDR_W-1:0]];
        end
        if (i_cmd.rd_out) begin
            r_has <= 1'b1;
        end else if (i_cmd.out_empty) begin
            r_has <= 1'b0;
        end
    end

    assign o_status.idx_zero    = (r_idx == '0);
    assign o_status.sp_zero     = (r_sp == '0);
    assign o_status.oc_zero     = (r_oc == '0);
    assign o_status.cur_operand = is_operand(cur_char);
    assign o_status.cur_open    = (cur_char == CH_OPEN);
    assign o_status.cur_close   = (cur_char == CH_CLOSE);
    assign o_status.pop_ok      = (cur_char == CH_CARET) ? (cur_prec <= top_prec)
                                                         : (cur_prec < top_prec);
    assign o_status.top_open    = (r_stk_q == CH_OPEN);

    assign o_char     = r_has ? r_out_q : 8'h00;
    assign o_has_char = r_has;
    assign o_last     = (r_oc == '0);
    assign o_overflow = r_ovf;

endmodule

// ===== rtl/i2p_ctrl.sv =====
// Controller state machine of the infix to prefix converter.
`timescale 1ns / 1ps
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_SCAN,
        S_CLASSIFY,
        S_CLOSE,
        S_CLOSE_CHK,
        S_OPER,
        S_OPER_CHK,
        S_FLUSH,
        S_FLUSH_POP,
        S_OUT_BEGIN,
        S_SHOW
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   in_acc, out_acc;

    assign in_acc  = r_in_ready && i_in_valid;
    assign out_acc = r_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.idx_zero) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.rd_in = 1'b1;
                    n_state     = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                if (i_status.cur_operand) begin
                    o_cmd.emit_cur = 1'b1;
                    n_state        = S_SCAN;
                end else if (i_status.cur_open) begin
                    o_cmd.push_cur = 1'b1;
                    n_state        = S_SCAN;
                end else if (i_status.cur_close) begin
                    if (i_status.sp_zero) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.rd_top = 1'b1;
                        n_state      = S_CLOSE;
                    end
                end else if (i_status.sp_zero) begin
                    o_cmd.push_cur = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.rd_top = 1'b1;
                    n_state      = S_OPER;
                end
            end
            S_CLOSE: begin
                if (i_status.top_open) begin
                    o_cmd.drop_top = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.pop_emit = 1'b1;
                    n_state        = S_CLOSE_CHK;
                end
            end
            S_CLOSE_CHK: begin
                if (i_status.sp_zero) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.rd_top = 1'b1;
                    n_state      = S_CLOSE;
                end
            end
            S_OPER: begin
                if (i_status.pop_ok) begin
                    o_cmd.pop_emit = 1'b1;
                    n_state        = S_OPER_CHK;
                end else begin
                    o_cmd.push_cur = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_OPER_CHK: begin
                if (i_status.sp_zero) begin
                    o_cmd.push_cur = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.rd_top = 1'b1;
                    n_state      = S_OPER;
                end
            end
            S_FLUSH: begin
                if (i_status.sp_zero) begin
                    n_state = S_OUT_BEGIN;
                end else begin
                    o_cmd.rd_top = 1'b1;
                    n_state      = S_FLUSH_POP;
                end
            end
            S_FLUSH_POP: begin
                o_cmd.pop_emit = 1'b1;
                n_state        = S_FLUSH;
            end
            S_OUT_BEGIN: begin
                if (i_status.oc_zero) begin
                    o_cmd.out_empty = 1'b1;
                end else begin
                    o_cmd.rd_out = 1'b1;
                end
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (out_acc) begin
                    if (i_status.oc_zero) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        o_cmd.rd_out = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_LOAD);
            r_out_valid <= (n_state == S_SHOW);
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/infix_to_prefix_converter_unit.sv =====
// Top level of the infix to prefix converter.
`timescale 1ns / 1ps
`include "infix_to_prefix_converter_unit_assert.svh"
// Characters of an infix expression arrive one per transaction until the transaction with
// tlast set; up to 32 are kept and later ones are dropped and reported as overflow. The
// block then converts the stored expression and streams the prefix string, one character
// per transaction with tlast on the final one; an empty result gives one transaction with
// has_char clear. Conversion is bounded by the single-port buffers and stack whose reads
// are registered; results then leave one per cycle while the receiver is ready, after a
// start state that issues the first read. No new character is taken until the last result
// of the expression is delivered.
module infix_to_prefix_converter_unit
    import i2p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // char_in [7:0]
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // char_out [7:0]
    output logic [1:0] o_m_axis_tuser,   // has_char [0], overflow [1]
    output logic       o_m_axis_tlast
);

    t_cmd    cmd;
    t_status status;
    logic    has_char;
    logic    overflow;

    i2p_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_last   (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid)
    );

    i2p_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (i_s_axis_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_char     (o_m_axis_tdata),
        .o_has_char (has_char),
        .o_last     (o_m_axis_tlast),
        .o_overflow (overflow)
    );

    assign o_m_axis_tuser = {overflow, has_char};

    `I2P_ASSERT_SAME(a_sides_exclusive, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready)
    `I2P_ASSERT_SAME(a_empty_is_last, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tlast)
    `I2P_ASSERT_NEXT(a_last_in_stops, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, !o_s_axis_tready)
    `I2P_ASSERT_NEXT(a_last_out_frees, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, o_s_axis_tready && !o_m_axis_tvalid)

endmodule

// ===== bench/infix_to_prefix_checker.sv =====
// Checker that predicts the prefix stream of the converter and compares every output transaction.
`timescale 1ns / 1ps
module infix_to_prefix_checker
    import i2p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // char_in [7:0]
    input  logic       i_s_axis_tlast,
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // char_out [7:0]
    input  logic [1:0] i_m_axis_tuser,   // has_char [0], overflow [1]
    input  logic       i_m_axis_tlast,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
        logic       ovf;
    } t_prefix_item;

    t_prefix_item prefix_expected[$];

    logic [7:0] expr_buf    [MAX_LEN];
    logic [7:0] op_stack    [MAX_LEN];
    logic [7:0] postfix_buf [MAX_LEN];
    int         expr_len    = 0;
    int         stack_top   = 0;
    int         postfix_len = 0;
    logic       expr_ovf    = 1'b0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int prec_level(input logic [7:0] c);
        if (c == CH_CARET) begin
            return 3;
        end
        if ((c == CH_STAR) || (c == CH_SLASH)) begin
            return 2;
        end
        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            return 1;
        end
        return -1;
    endfunction

    function automatic logic operand_char(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
               ((c >= CH_ZERO) && (c <= CH_NINE));
    endfunction

    task automatic append_postfix(input logic [7:0] c);
        if (postfix_len < MAX_LEN) begin
            postfix_buf[postfix_len] = c;
            postfix_len++;
        end
    endtask

    task automatic push_operator(input logic [7:0] c);
        if (stack_top < MAX_LEN) begin
            op_stack[stack_top] = c;
            stack_top++;
        end
    endtask

    task automatic pop_to_postfix();
        stack_top--;
        append_postfix(op_stack[stack_top]);
    endtask

    // Scan the stored expression backwards with parentheses swapped, build the postfix
    // string, then queue it in reverse order as the expected prefix stream.
    task automatic build_prefix();
        logic [7:0]   c;
        int           p;
        int           i;
        int           k;
        t_prefix_item item;
        stack_top   = 0;
        postfix_len = 0;
        for (i = expr_len; i > 0; i--) begin
            c = expr_buf[i - 1];
            if (c == CH_OPEN) begin
                c = CH_CLOSE;
            end else if (c == CH_CLOSE) begin
                c = CH_OPEN;
            end
            if (operand_char(c)) begin
                append_postfix(c);
            end else if (c == CH_OPEN) begin
                push_operator(c);
            end else if (c == CH_CLOSE) begin
                while ((stack_top > 0) && (op_stack[stack_top - 1] != CH_OPEN)) begin
                    pop_to_postfix();
                end
                if (stack_top > 0) begin
                    stack_top--;
                end
            end else begin
                p = prec_level(c);
                if (c == CH_CARET) begin
                    while ((stack_top > 0) && (p <= prec_level(op_stack[stack_top - 1]))) begin
                        pop_to_postfix();
                    end
                end else begin
                    while ((stack_top > 0) && (p < prec_level(op_stack[stack_top - 1]))) begin
                        pop_to_postfix();
                    end
                end
                push_operator(c);
            end
        end
        while (stack_top > 0) begin
            pop_to_postfix();
        end
        if (postfix_len == 0) begin
            item = '{ch: 8'h00, has_char: 1'b0, last: 1'b1, ovf: expr_ovf};
            prefix_expected.push_back(item);
        end else begin
            for (k = postfix_len; k > 0; k--) begin
                item = '{ch: postfix_buf[k - 1], has_char: 1'b1, last: (k == 1), ovf: expr_ovf};
                prefix_expected.push_back(item);
            end
        end
        expr_len  = 0;
        stack_top = 0;
        expr_ovf  = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_prefix_item want;
        if (!i_rst_n) begin
            expr_len  = 0;
            stack_top = 0;
            expr_ovf  = 1'b0;
            prefix_expected.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (prefix_expected.size() == 0) begin
                    $error("unexpected output transaction: char_out %0h", i_m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = prefix_expected.pop_front();
                    if (i_m_axis_tdata !== want.ch) begin
                        $error("char_out: expected %0h, actual %0h", want.ch, i_m_axis_tdata);
                        o_fail_count++;
                    end
                    if (i_m_axis_tuser[0] !== want.has_char) begin
                        $error("has_char: expected %0b, actual %0b", want.has_char,
                               i_m_axis_tuser[0]);
                        o_fail_count++;
                    end
                    if (i_m_axis_tlast !== want.last) begin
                        $error("last_out: expected %0b, actual %0b", want.last, i_m_axis_tlast);
                        o_fail_count++;
                    end
                    if (i_m_axis_tuser[1] !== want.ovf) begin
                        $error("overflow: expected %0b, actual %0b", want.ovf, i_m_axis_tuser[1]);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (expr_len < MAX_LEN) begin
                    expr_buf[expr_len] = i_s_axis_tdata;
                    expr_len++;
                end else begin
                    expr_ovf = 1'b1;
                end
                if (i_s_axis_tlast) begin
                    build_prefix();
                end
            end
        end
        o_pending = prefix_expected.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the converter testbench: clock, reset, stimulus, stall control and verdict.
`timescale 1ns / 1ps
module testbench;
    import i2p_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 410;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       s_last  = 1'b0;
    logic       m_ready = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [7:0] m_data;                  // char_out [7:0]
    wire  [1:0] m_user;                  // has_char [0], overflow [1]
    wire        m_last;

    int   fail_count;
    int   pending;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic rx_hold      = 1'b0;
    int   rx_held      = 0;
    int   quiet_cycles = 0;
    int   sent_items   = 0;
    int   random_base;
    int   phase;

    logic [7:0] expr_chars[$];
    logic [7:0] operator_set[5] = '{CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS};

    infix_to_prefix_converter_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last)
    );

    infix_to_prefix_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .i_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .i_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .i_m_axis_tdata (m_data),
        .i_m_axis_tuser (m_user),
        .i_m_axis_tlast (m_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver holds off for a counted stretch while rx_hold is set.
    always @(negedge clk) begin
        if (rx_hold && (rx_held < HOLD_CYCLES)) begin
            m_ready <= 1'b0;
            rx_held <= rx_held + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
            if (!rx_hold) begin
                rx_held <= 0;
            end
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= is_last;
        @(posedge clk);
        while (!s_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        sent_items++;
    endtask

    task automatic send_expression();
        int i;
        for (i = 0; i < expr_chars.size(); i++) begin
            send_char(expr_chars[i], i == expr_chars.size() - 1);
        end
    endtask

    task automatic send_text(input string text);
        int i;
        expr_chars.delete();
        for (i = 0; i < text.len(); i++) begin
            expr_chars.push_back(text[i]);
        end
        send_expression();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    function automatic logic [7:0] random_operand();
        case ($urandom_range(2))
            0:       return CH_UP_A + 8'($urandom_range(25));
            1:       return CH_LO_A + 8'($urandom_range(25));
            default: return CH_ZERO + 8'($urandom_range(9));
        endcase
    endfunction

    function automatic logic [7:0] random_symbol();
        case ($urandom_range(3))
            0:       return random_operand();
            1:       return operator_set[$urandom_range(4)];
            2:       return $urandom_range(1) ? CH_OPEN : CH_CLOSE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic build_random_expression();
        int kind;
        int n_ops;
        int depth;
        int len;
        int i;
        expr_chars.delete();
        kind = $urandom_range(99);
        if (kind < 70) begin
            n_ops = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
            depth = 0;
            for (i = 0; i <= n_ops; i++) begin
                while (($urandom_range(3) == 0) && (depth < 4)) begin
                    expr_chars.push_back(CH_OPEN);
                    depth++;
                end
                expr_chars.push_back(random_operand());
                while ((depth > 0) && ($urandom_range(2) == 0)) begin
                    expr_chars.push_back(CH_CLOSE);
                    depth--;
                end
                if (i < n_ops) begin
                    expr_chars.push_back(operator_set[$urandom_range(4)]);
                end
            end
            while (depth > 0) begin
                expr_chars.push_back(CH_CLOSE);
                depth--;
            end
        end else if (kind < 85) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
                expr_chars.push_back(random_symbol());
            end
        end else if (kind < 95) begin
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
                expr_chars.push_back(8'($urandom_range(255)));
            end
        end else begin
            len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
            for (i = 0; i < len; i++) begin
                expr_chars.push_back(random_symbol());
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("(");
        send_text(")");
        send_text("Z");
        send_text("A+B*C");
        send_text("a^b^c");
        send_text("(0-9)/z");
        expr_chars = '{8'h00, 8'hFF, CH_NINE};
        send_expression();
        wait_drained();

        random_base = sent_items;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct  <= 62;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 62;
                end
                default: begin
                    tx_idle_pct  <= 26;
                    rx_stall_pct <= 26;
                end
            endcase
            if (phase == 0) begin
                rx_hold <= 1'b1;
                repeat (4) begin
                    build_random_expression();
                    send_expression();
                end
                rx_hold <= 1'b0;
            end
            while (sent_items - random_base < RANDOM_ITEMS * (phase + 1) / 4) begin
                build_random_expression();
                send_expression();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if ((fail_count == 0) && (pending == 0)) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
